// ===== rtl/fnvmix_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnvmix_pkg
// Shared types, constants and hash functions for the FNV-1a hash core.
// ----------------------------------------------------------------------------
package fnvmix_pkg;

	localparam int unsigned HASH_W = 32;
	localparam int unsigned BYTE_W = 8;

	localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
	localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;

	localparam int unsigned MIX_SH1 = 13;
	localparam int unsigned MIX_SH2 = 7;
	localparam int unsigned MIX_SH3 = 3;
	localparam int unsigned MIX_SH4 = 17;
	localparam int unsigned MIX_SH5 = 5;

	typedef logic [HASH_W-1:0] hash_t;

	// closed message handed from the accumulator to the finalizer
	typedef struct packed {
		logic  valid;
		hash_t hash;
	} mix_req_t;

	function automatic hash_t fnv_step(input hash_t h, input logic [BYTE_W-1:0] b);
		hash_t x;
		x = h ^ {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
		return x * FNV_PRIME;
	endfunction

	function automatic hash_t final_mix(input hash_t h_in);
		hash_t h;
		h = h_in;
		h = h + (h << MIX_SH1);
		h = h ^ (h >> MIX_SH2);
		h = h + (h << MIX_SH3);
		h = h ^ (h >> MIX_SH4);
		h = h + (h << MIX_SH5);
		return h;
	endfunction

endpackage

// ===== rtl/fnvmix_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnvmix_in_if
// Message byte channel: valid/ready with byte, byte-present and last flags.
// ----------------------------------------------------------------------------
interface fnvmix_in_if;
	import fnvmix_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              has_byte;
	logic              last;

	modport source (output valid, output data_byte, output has_byte, output last,
		input ready);
	modport sink (input valid, input data_byte, input has_byte, input last,
		output ready);
endinterface

// ===== rtl/fnvmix_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnvmix_out_if
// Hash result channel: valid/ready with the 32-bit finalized hash.
// ----------------------------------------------------------------------------
interface fnvmix_out_if;
	import fnvmix_pkg::*;

	logic  valid;
	logic  ready;
	hash_t hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

// ===== rtl/fnvmix_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnvmix_accum
// Running FNV-1a state; captures the closing hash of each message into s1.
// ----------------------------------------------------------------------------
module fnvmix_accum
	import fnvmix_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	fnvmix_in_if.sink       msg,
	output mix_req_t        req,
	input  logic            req_ready
);

	hash_t running_hash_q;
	hash_t hash_s1;
	logic  valid_s1;
	hash_t upd;
	logic  accept;

	assign msg.ready = !valid_s1 || req_ready;
	assign accept    = msg.valid && msg.ready;
	assign upd       = msg.has_byte ? fnv_step(running_hash_q, msg.data_byte)
		: running_hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_hash_q <= FNV_BASIS;
			valid_s1       <= 1'b0;
		end else begin
			if (accept) begin
				running_hash_q <= msg.last ? FNV_BASIS : upd;
				valid_s1       <= msg.last;
			end else if (req_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && msg.last) begin
			hash_s1 <= upd;
		end
	end

	assign req.valid = valid_s1;
	assign req.hash  = hash_s1;

endmodule

// ===== rtl/fnvmix_final.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnvmix_final
// Avalanche finalizer and output register.
// ----------------------------------------------------------------------------
module fnvmix_final
	import fnvmix_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  mix_req_t        req,
	output logic            req_ready,
	fnvmix_out_if.source    res
);

	logic  valid_q;
	hash_t hash_q;

	assign req_ready = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req.valid && req_ready) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req_ready) begin
			hash_q <= final_mix(req.hash);
		end
	end

	assign res.valid      = valid_q;
	assign res.hash_value = hash_q;

endmodule

// ===== rtl/fnv1a_hash_with_final_mix_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnv1a_hash_with_final_mix_core
// FNV-1a-style 32-bit hash of sign-extended bytes; shift-add/xor finalizer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  msg      in   valid/ready  data_byte[7:0], has_byte, last
//  res      out  valid/ready  hash_value[31:0]
//
//  One item per cycle while msg is ready. The running hash updates in
//  the accept cycle (xor + constant multiply); a closing item's hash
//  enters s1, then the finalizer fills the output register. Reset loads
//  the offset basis and empties both stages.
//  Stalls on res back up through s1; msg stalls only when both are full.
// ----------------------------------------------------------------------------
module fnv1a_hash_with_final_mix_core
	import fnvmix_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	fnvmix_in_if.sink     msg,
	fnvmix_out_if.source  res
);

	mix_req_t req;
	logic     req_ready;

	fnvmix_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.req       (req),
		.req_ready (req_ready)
	);

	fnvmix_final u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_ready (req_ready),
		.res       (res)
	);

	a_last_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		msg.valid && msg.ready && msg.last |=> req.valid)
		else $error("closing transaction did not reach finalizer stage");

	a_nonlast_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		msg.valid && msg.ready && !msg.last && !req.valid |=> !req.valid)
		else $error("non-closing transaction produced a pending result");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && !req_ready |=> req.valid && $stable(req.hash))
		else $error("stalled finalizer request lost or changed");

	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req_ready |=> res.valid)
		else $error("finalizer request did not reach output register");

endmodule
